// ===== rtl/dirty_rect_coalescer_core_macros.svh =====
// Assertion macros shared by the dirty-rectangle coalescer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef DIRTY_RECT_COALESCER_CORE_MACROS_SVH
`define DIRTY_RECT_COALESCER_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DRC_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Property checked during reset as well.
`define DRC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/drc_pkg.sv =====
// Package for the dirty-rectangle coalescer: op and status codes, command
// and status structs between controller and datapath. No dependencies.
package drc_pkg;

    localparam int CW = 16;

    typedef enum logic [1:0] {
        OP_STORE = 2'd0,
        OP_FLUSH = 2'd1,
        OP_CLEAR = 2'd2,
        OP_DELAY = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_REJECTED = 3'd1,
        ST_REGION   = 3'd2,
        ST_NOTHING  = 3'd3,
        ST_DELAYED  = 3'd4,
        ST_OVERFLOW = 3'd5
    } status_t;

    localparam logic [2:0] CFG_MAIN_W = 3'd0;
    localparam logic [2:0] CFG_MAIN_H = 3'd1;
    localparam logic [2:0] CFG_SUB_W  = 3'd2;
    localparam logic [2:0] CFG_SUB_H  = 3'd3;
    localparam logic [2:0] CFG_GAP    = 3'd4;

    typedef struct packed {
        logic signed [CW-1:0] l;
        logic signed [CW-1:0] t;
        logic signed [CW-1:0] r;
        logic signed [CW-1:0] b;
    } box_t;

    // Controller -> datapath.
    typedef struct packed {
        logic load;       // capture request rectangle and clip it
        logic sel_sub;    // table/display chosen for scan, emit, write
        logic rd;         // issue table read at index
        logic wr_new;     // write candidate at index
        logic wr_full;    // write full-display box at index
        logic wr_move;    // write read data at index (compaction)
        logic merge;      // candidate becomes bounding box with read data
        logic cap;        // hold the clipped region of the read entry
        logic emit;       // move the held region to the result register
    } drc_cmd_t;

    // Datapath -> controller.
    typedef struct packed {
        logic invalid;
        logic zero;
        logic covers;
        logic joinable;
        logic visible;
    } drc_sts_t;

endpackage

// ===== rtl/drc_datapath.sv =====
// Datapath of the dirty-rectangle coalescer: two table memories, the
// candidate register, clipping and merge tests. Uses drc_pkg.
module drc_datapath
    import drc_pkg::*;
#(
    parameter int MAX_RECTS  = 16,
    parameter int COORD_BITS = 16,
    parameter int IW = $clog2(MAX_RECTS)
) (
    input  logic          aclk,
    input  logic [15:0]   in_l,
    input  logic [15:0]   in_t,
    input  logic [15:0]   in_r,
    input  logic [15:0]   in_b,
    input  logic [12:0]   main_w,
    input  logic [12:0]   main_h,
    input  logic [12:0]   sub_w,
    input  logic [12:0]   sub_h,
    input  logic [15:0]   gap,
    input  drc_cmd_t      cmd,
    input  logic [IW-1:0] rd_idx,
    input  logic [IW-1:0] wr_idx,
    output drc_sts_t      sts,
    output box_t          region
);
    box_t main_mem [MAX_RECTS];
    box_t sub_mem  [MAX_RECTS];
    box_t rd_main_reg, rd_sub_reg, rd_q;
    box_t cand_reg, cand_next;
    logic invalid_reg;

    localparam logic signed [17:0] CMAX = 18'sd2 ** (COORD_BITS-1) - 18'sd1;

    function automatic logic signed [CW-1:0] sx(input logic [15:0] v);
        logic [COORD_BITS-1:0] x;
        x = v[COORD_BITS-1:0];
        return CW'(signed'(x));
    endfunction

    function automatic logic signed [17:0] lim(input logic [12:0] s);
        logic signed [17:0] v;
        v = signed'({5'd0, s}) - 18'sd1;
        return (v > CMAX) ? CMAX : v;
    endfunction

    function automatic logic signed [17:0] dst(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b);
        logic signed [17:0] d;
        d = 18'(a) - 18'(b);
        return d < 0 ? -d : d;
    endfunction

    logic signed [17:0] lw, lh;
    box_t nb, fullb, mt;
    logic signed [17:0] d0, d1, d2, d3, dmin;
    logic signed [CW-1:0] sl, st, sr, sb;

    assign lw = lim(cmd.sel_sub ? sub_w : main_w);
    assign lh = lim(cmd.sel_sub ? sub_h : main_h);
    assign rd_q = cmd.sel_sub ? rd_sub_reg : rd_main_reg;

    always_comb begin
        sl = sx(in_l); st = sx(in_t); sr = sx(in_r); sb = sx(in_b);
        nb.l = sl; nb.t = st;
        nb.r = (18'(sr) > lw) ? lw[CW-1:0] : sr;
        nb.b = (18'(sb) > lh) ? lh[CW-1:0] : sb;
        fullb.l = '0; fullb.t = '0; fullb.r = lw[CW-1:0]; fullb.b = lh[CW-1:0];
        cand_next = cand_reg;
        if (cmd.load) cand_next = nb;
        else if (cmd.merge) begin
            cand_next.l = (rd_q.l < cand_reg.l) ? rd_q.l : cand_reg.l;
            cand_next.t = (rd_q.t < cand_reg.t) ? rd_q.t : cand_reg.t;
            cand_next.r = (rd_q.r > cand_reg.r) ? rd_q.r : cand_reg.r;
            cand_next.b = (rd_q.b > cand_reg.b) ? rd_q.b : cand_reg.b;
        end
        d0 = dst(rd_q.t, cand_reg.t); d1 = dst(rd_q.t, cand_reg.b);
        d2 = dst(rd_q.b, cand_reg.t); d3 = dst(rd_q.b, cand_reg.b);
        dmin = d0;
        if (d1 < dmin) dmin = d1;
        if (d2 < dmin) dmin = d2;
        if (d3 < dmin) dmin = d3;
        mt.l = (rd_q.l > cand_reg.l) ? rd_q.l : cand_reg.l;
        mt.t = (rd_q.t > cand_reg.t) ? rd_q.t : cand_reg.t;
        mt.r = (rd_q.r < cand_reg.r) ? rd_q.r : cand_reg.r;
        mt.b = (rd_q.b < cand_reg.b) ? rd_q.b : cand_reg.b;
        sts.invalid = invalid_reg;
        sts.zero = (cand_reg == '0);
        sts.covers = cand_reg.l >= rd_q.l && cand_reg.t >= rd_q.t &&
                     cand_reg.r <= rd_q.r && cand_reg.b <= rd_q.b;
        sts.joinable = (mt.l <= mt.r && mt.t <= mt.b) || (dmin < signed'({2'b0, gap}));
        region.l = (rd_q.l > 0) ? rd_q.l : '0;
        region.t = (rd_q.t > 0) ? rd_q.t : '0;
        region.r = (18'(rd_q.r) < lw) ? rd_q.r : lw[CW-1:0];
        region.b = (18'(rd_q.b) < lh) ? rd_q.b : lh[CW-1:0];
        sts.visible = region.l <= region.r && region.t <= region.b;
    end

    always_ff @(posedge aclk) begin
        cand_reg <= cand_next;
        if (cmd.load) invalid_reg <= (sl > sr) || (st > sb);
        if (cmd.rd) begin
            rd_main_reg <= main_mem[rd_idx];
            rd_sub_reg  <= sub_mem[rd_idx];
        end
        if (cmd.wr_new || cmd.wr_full || cmd.wr_move) begin
            if (cmd.sel_sub)
                sub_mem[wr_idx] <= cmd.wr_new ? cand_reg : (cmd.wr_full ? fullb : rd_q);
            else
                main_mem[wr_idx] <= cmd.wr_new ? cand_reg : (cmd.wr_full ? fullb : rd_q);
        end
    end
endmodule

// ===== rtl/drc_ctrl.sv =====
// Controller state machine of the dirty-rectangle coalescer: sequences
// scan, merge, compaction and flush walks. Uses drc_pkg and the macros.
`include "dirty_rect_coalescer_core_macros.svh"
module drc_ctrl
    import drc_pkg::*;
#(
    parameter int MAX_RECTS = 16,
    parameter int IW = $clog2(MAX_RECTS)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [1:0]    in_op,
    input  logic          in_sel,
    input  logic [7:0]    in_delay,
    input  logic          in_bl,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [2:0]    o_status,
    output logic          o_disp,
    output logic          o_last,
    output logic          o_region,
    output drc_cmd_t      cmd,
    output logic [IW-1:0] rd_idx,
    output logic [IW-1:0] wr_idx,
    input  drc_sts_t      sts
);
    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SCAN, S_TEST, S_SHIFT_RD, S_SHIFT_WR,
        S_APPEND, S_FL_RD, S_FL_TEST, S_OUT
    } state_t;

    localparam logic [IW:0] MAXC = (IW+1)'(MAX_RECTS);

    state_t state_reg;
    logic [IW:0] main_cnt_reg, sub_cnt_reg, idx_reg;
    logic [7:0] delay_reg;
    logic sel_reg, emitted_reg, ret_fl_reg;
    logic [2:0] st_reg;
    logic disp_reg, last_reg, region_reg, valid_reg;
    logic [IW:0] cnt;

    assign cnt = sel_reg ? sub_cnt_reg : main_cnt_reg;
    assign s_tready = (state_reg == S_IDLE) && !valid_reg;
    assign m_tvalid = valid_reg;
    assign o_status = st_reg;
    assign o_disp = disp_reg;
    assign o_last = last_reg;
    assign o_region = region_reg;
    assign rd_idx = idx_reg[IW-1:0];

    always_comb begin
        cmd = '0;
        cmd.sel_sub = sel_reg;
        wr_idx = idx_reg[IW-1:0];
        unique case (state_reg)
            S_IDLE: begin
                cmd.load = s_tready && s_tvalid;
                cmd.sel_sub = in_sel;
            end
            S_SCAN, S_FL_RD, S_SHIFT_RD: cmd.rd = 1'b1;
            S_TEST: cmd.merge = !sts.covers && sts.joinable;
            S_SHIFT_WR: begin
                cmd.wr_move = 1'b1;
                wr_idx = IW'(idx_reg - 1'b1);
            end
            S_APPEND: begin
                cmd.wr_new = (cnt != MAXC);
                cmd.wr_full = (cnt == MAXC);
                wr_idx = (cnt == MAXC) ? '0 : cnt[IW-1:0];
            end
            S_FL_TEST: cmd.cap = sts.visible && !emitted_reg;
            S_OUT: cmd.emit = !valid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            main_cnt_reg <= '0; sub_cnt_reg <= '0; delay_reg <= '0;
            valid_reg <= 1'b0; idx_reg <= '0; sel_reg <= 1'b0;
            emitted_reg <= 1'b0; ret_fl_reg <= 1'b0;
            st_reg <= ST_ACCEPTED; disp_reg <= 1'b0; last_reg <= 1'b0;
            region_reg <= 1'b0;
        end else begin
            if (valid_reg && m_tready && state_reg != S_OUT) valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_tready && s_tvalid) begin
                    disp_reg <= 1'b0; last_reg <= 1'b1; region_reg <= 1'b0;
                    st_reg <= ST_ACCEPTED;
                    unique case (op_t'(in_op))
                        OP_STORE: begin
                            sel_reg <= in_sel;
                            state_reg <= S_CHECK;
                        end
                        OP_FLUSH: if (delay_reg != 8'd0) begin
                            delay_reg <= delay_reg - 8'd1;
                            st_reg <= ST_DELAYED; valid_reg <= 1'b1;
                        end else if (!in_bl) begin
                            st_reg <= ST_NOTHING; valid_reg <= 1'b1;
                        end else begin
                            sel_reg <= 1'b0; idx_reg <= '0; emitted_reg <= 1'b0;
                            state_reg <= S_FL_RD;
                        end
                        OP_CLEAR: begin
                            main_cnt_reg <= '0; valid_reg <= 1'b1;
                        end
                        OP_DELAY: begin
                            delay_reg <= in_delay; valid_reg <= 1'b1;
                        end
                        default: ;
                    endcase
                end
                S_CHECK: begin
                    idx_reg <= '0;
                    if (sts.invalid) begin
                        st_reg <= ST_REJECTED; valid_reg <= 1'b1; state_reg <= S_IDLE;
                    end else if (sts.zero) begin
                        valid_reg <= 1'b1; state_reg <= S_IDLE;
                    end else state_reg <= S_SCAN;
                end
                S_SCAN: state_reg <= (idx_reg < cnt) ? S_TEST : S_APPEND;
                S_TEST: if (sts.covers) begin
                    valid_reg <= 1'b1; state_reg <= S_IDLE;
                end else if (sts.joinable) begin
                    idx_reg <= idx_reg + 1'b1;
                    state_reg <= S_SHIFT_RD;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                    state_reg <= S_SCAN;
                end
                S_SHIFT_RD: if (idx_reg < cnt) state_reg <= S_SHIFT_WR;
                else begin
                    if (sel_reg) sub_cnt_reg <= sub_cnt_reg - 1'b1;
                    else main_cnt_reg <= main_cnt_reg - 1'b1;
                    idx_reg <= '0;
                    state_reg <= S_SCAN;
                end
                S_SHIFT_WR: begin
                    idx_reg <= idx_reg + 1'b1;
                    state_reg <= S_SHIFT_RD;
                end
                S_APPEND: begin
                    if (cnt == MAXC) begin
                        st_reg <= ST_OVERFLOW;
                        if (sel_reg) sub_cnt_reg <= (IW+1)'(1);
                        else main_cnt_reg <= (IW+1)'(1);
                    end else if (sel_reg) sub_cnt_reg <= sub_cnt_reg + 1'b1;
                    else main_cnt_reg <= main_cnt_reg + 1'b1;
                    valid_reg <= 1'b1; state_reg <= S_IDLE;
                end
                S_FL_RD: if (idx_reg < cnt) state_reg <= S_FL_TEST;
                else if (!sel_reg) begin
                    sel_reg <= 1'b1; idx_reg <= '0;
                end else begin
                    main_cnt_reg <= '0; sub_cnt_reg <= '0;
                    if (emitted_reg) begin
                        state_reg <= S_OUT;
                    end else begin
                        st_reg <= ST_NOTHING; disp_reg <= 1'b0; region_reg <= 1'b0;
                        last_reg <= 1'b1; valid_reg <= 1'b1; state_reg <= S_IDLE;
                    end
                end
                S_FL_TEST: begin
                    if (sts.visible && emitted_reg) begin
                        // One region is already held so that last is exact. It
                        // goes out first, then this entry is read and tested again.
                        ret_fl_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        if (sts.visible) emitted_reg <= 1'b1;
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_FL_RD;
                    end
                end
                S_OUT: if (!valid_reg || m_tready) begin
                    valid_reg <= 1'b1; st_reg <= ST_REGION; region_reg <= 1'b1;
                    emitted_reg <= 1'b0;
                    if (ret_fl_reg) begin
                        last_reg <= 1'b0; ret_fl_reg <= 1'b0; state_reg <= S_FL_RD;
                    end else begin
                        last_reg <= 1'b1; state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `DRC_ASSERT_CLK(a_cnt_main, aclk, aresetn, main_cnt_reg <= MAXC, "main count overflow")
    `DRC_ASSERT_CLK(a_cnt_sub, aclk, aresetn, sub_cnt_reg <= MAXC, "sub count overflow")
    `DRC_ASSERT_CLK(a_ready_idle, aclk, aresetn, s_tready |-> state_reg == S_IDLE, "ready busy")
    `DRC_ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> !m_tvalid, "valid after reset")
endmodule

// ===== rtl/drc_out.sv =====
// Output registers for region results: a held region found by the flush walk
// and the region that goes with the request on the result channel. Uses drc_pkg.
module drc_out
    import drc_pkg::*;
(
    input  logic aclk,
    input  logic capture,
    input  logic load,
    input  logic sel,
    input  box_t region,
    output box_t box_q,
    output logic disp_q
);
    box_t pend_box_reg, box_reg;
    logic pend_disp_reg, disp_reg;
    always_ff @(posedge aclk) begin
        if (capture) begin
            pend_box_reg <= region;
            pend_disp_reg <= sel;
        end
        if (load) begin
            box_reg <= pend_box_reg;
            disp_reg <= pend_disp_reg;
        end
    end
    assign box_q = box_reg;
    assign disp_q = disp_reg;
endmodule

// ===== rtl/dirty_rect_coalescer_core.sv =====
// Dirty-rectangle coalescer for a main and a secondary display. Each request
// carries an op: store a rectangle, flush, clear the main table or set a flush
// delay. A store is validated, clipped on its right and bottom edges, then
// scanned against that display's table, each entry read and then tested; a
// merge removes the entry by shifting the tail down, each moved entry read
// and then written, and restarts the scan. A flush, unless a delay is pending
// or the backlight is off, walks both tables, reading and testing each entry,
// and gives one region result per visible entry, main display first. One
// visible region is held back until the next is found so that the last flag
// is exact; each visible entry after the first is therefore read and tested
// again once the held region has gone out, which may wait on the result
// channel. The controller is a single state machine handling one request at
// a time; the table memories have one registered read port.
// Results wait in an output register; no new request is taken until the
// current one is fully delivered.
module dirty_rect_coalescer_core
    import drc_pkg::*;
#(
    parameter int MAX_RECTS  = 16,
    parameter int COORD_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: op[1:0], display_sel[2], rect_left[18:3], rect_top[34:19],
    // rect_right[50:35], rect_bottom[66:51], delay_value[74:67],
    // backlight_on[75], zero fill to 80 bits
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: status[2:0], out_display[3], out_left[19:4], out_top[35:20],
    // out_right[51:36], out_bottom[67:52], zero fill to 72 bits
    output logic [71:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int IW = $clog2(MAX_RECTS);

    logic [12:0] main_w_reg, main_h_reg, sub_w_reg, sub_h_reg;
    logic [15:0] gap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_w_reg <= 13'd240; main_h_reg <= 13'd320;
            sub_w_reg <= 13'd128; sub_h_reg <= 13'd64; gap_reg <= 16'd40;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MAIN_W: main_w_reg <= cfg_data[12:0];
                CFG_MAIN_H: main_h_reg <= cfg_data[12:0];
                CFG_SUB_W:  sub_w_reg <= cfg_data[12:0];
                CFG_SUB_H:  sub_h_reg <= cfg_data[12:0];
                CFG_GAP:    gap_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    drc_cmd_t cmd;
    drc_sts_t sts;
    logic [IW-1:0] rd_idx, wr_idx;
    box_t region, box_q;
    logic [2:0] o_status;
    logic o_disp, o_last, o_region, disp_q;

    drc_datapath #(.MAX_RECTS(MAX_RECTS), .COORD_BITS(COORD_BITS), .IW(IW)) u_dp (
        .aclk, .in_l(s_tdata[18:3]), .in_t(s_tdata[34:19]),
        .in_r(s_tdata[50:35]), .in_b(s_tdata[66:51]),
        .main_w(main_w_reg), .main_h(main_h_reg), .sub_w(sub_w_reg),
        .sub_h(sub_h_reg), .gap(gap_reg), .cmd, .rd_idx, .wr_idx, .sts, .region
    );

    drc_ctrl #(.MAX_RECTS(MAX_RECTS), .IW(IW)) u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .in_op(s_tdata[1:0]),
        .in_sel(s_tdata[2]), .in_delay(s_tdata[74:67]), .in_bl(s_tdata[75]),
        .m_tvalid, .m_tready, .o_status, .o_disp, .o_last, .o_region,
        .cmd, .rd_idx, .wr_idx, .sts
    );

    // A visible region is held when the walk tests it; it moves to the
    // result register when the controller sends it, once the next region
    // is known or the walk has ended.
    drc_out u_out (
        .aclk, .capture(cmd.cap), .load(cmd.emit),
        .sel(cmd.sel_sub), .region, .box_q, .disp_q
    );

    box_t ob;
    assign ob = o_region ? box_q : '0;
    assign m_tdata = {4'd0, ob.b, ob.r, ob.t, ob.l, (o_region ? disp_q : 1'b0), o_status};
    assign m_tlast = o_last;
    logic unused_disp;
    assign unused_disp = o_disp;
endmodule
